FILE: hdl/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg: shared constants and types of the RGB bilateral filter
// Sizes of the line store and weight tables, accumulator widths, codes.
// ----------------------------------------------------------------------------
`default_nettype none
package bfr_pkg;

  localparam int HALF_MAX     = 7;
  localparam int LINE_MAX     = 1024;
  localparam int WEIGHT_BITS  = 16;
  localparam int HEIGHT_LIMIT = 4096;

  localparam int RING_SIZE   = 2 * HALF_MAX * LINE_MAX + 2 * HALF_MAX + 1;
  localparam int RING_AW     = $clog2(RING_SIZE);
  localparam int SPACE_DEPTH = 2 * HALF_MAX * HALF_MAX + 1;
  localparam int SPACE_AW    = $clog2(SPACE_DEPTH);
  localparam int HW_BITS     = $clog2(HALF_MAX + 1);
  localparam int OFS_W       = HW_BITS + 1;
  localparam int COL_W       = $clog2(LINE_MAX);
  localparam int ROW_W       = $clog2(HEIGHT_LIMIT);
  localparam int DELAY_MAX   = HALF_MAX * LINE_MAX + HALF_MAX;
  localparam int PEND_W      = $clog2(DELAY_MAX + 2);
  localparam int WIN_MAX     = (2 * HALF_MAX + 1) * (2 * HALF_MAX + 1);
  localparam int ACC_X       = $clog2(WIN_MAX);
  localparam int WT_W        = 2 * WEIGHT_BITS;
  localparam int NORM_W      = WT_W + ACC_X;
  localparam int SUM_W       = WT_W + 8 + ACC_X;
  localparam int DIV_W       = SUM_W + 1;
  localparam int LANES       = 3;

  typedef enum logic [1:0] {
    CMD_PIXEL  = 2'd0,
    CMD_FLUSH  = 2'd1,
    CMD_COLOUR = 2'd2,
    CMD_SPACE  = 2'd3
  } bfr_cmd_e;

  localparam logic [1:0] CFG_HALF   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CRD, ST_SETUP, ST_LOOP, ST_DRAIN, ST_DIV, ST_DONE
  } bfr_state_e;

  // colour weight table write, broadcast to every lane
  typedef struct packed {
    logic                   we;
    logic [7:0]             addr;
    logic [WEIGHT_BITS-1:0] data;
  } bfr_tbl_wr_t;

  // sequencer to lane control
  typedef struct packed {
    logic clr;
    logic use_nb;
    logic start;
  } bfr_lane_ctl_t;

  // lane to sequencer status
  typedef struct packed {
    logic       busy;
    logic [7:0] res;
  } bfr_lane_sts_t;

endpackage
`default_nettype wire

FILE: hdl/bfr_ram.sv
// ----------------------------------------------------------------------------
// bfr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module bfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bfr_lane.sv
// ----------------------------------------------------------------------------
// bfr_lane: one colour channel of the bilateral filter
// Colour weight lookup, weight products, accumulation and rounding divide.
// ----------------------------------------------------------------------------
`default_nettype none
module bfr_lane (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire bfr_pkg::bfr_tbl_wr_t           tbl_wr_i,
  input  wire bfr_pkg::bfr_lane_ctl_t         ctl_i,
  input  wire logic [7:0]                     sample_i,
  input  wire logic [7:0]                     centre_i,
  input  wire logic [bfr_pkg::WEIGHT_BITS-1:0] sw_i,
  output bfr_pkg::bfr_lane_sts_t              sts_o
);
  import bfr_pkg::*;

  logic [7:0]             diff;
  logic [WEIGHT_BITS-1:0] cw;
  logic [7:0]             s1_q, s2_q;
  logic [WEIGHT_BITS-1:0] sw1_q;
  logic [WT_W-1:0]        wt_q, wt3_q;
  logic [WT_W+7:0]        prod_q;
  logic                   use2_q, use3_q, use4_q;
  logic [NORM_W-1:0]      norm_q;
  logic [SUM_W-1:0]       sum_q;
  logic [DIV_W-1:0]       rem_q, dv_q;
  logic [7:0]             quo_q;
  logic [2:0]             cnt_q;
  logic                   busy_q, zero_q;
  logic                   take;

  // absolute channel difference selects the colour weight
  assign diff = (sample_i > centre_i) ? (sample_i - centre_i) : (centre_i - sample_i);

  bfr_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(256)) u_colour (
    .clk_i   (clk_i),
    .we_i    (tbl_wr_i.we),
    .waddr_i (tbl_wr_i.addr),
    .wdata_i (tbl_wr_i.data),
    .re_i    (1'b1),
    .raddr_i (diff),
    .rdata_o (cw)
  );

  // weight pipeline payload
  always_ff @(posedge clk_i) begin
    s1_q   <= sample_i;
    sw1_q  <= sw_i;
    s2_q   <= s1_q;
    wt_q   <= WT_W'(cw) * WT_W'(sw1_q);
    wt3_q  <= wt_q;
    prod_q <= (WT_W + 8)'(wt_q) * (WT_W + 8)'(s2_q);
  end

  // neighbour valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use2_q <= 1'b0;
      use3_q <= 1'b0;
      use4_q <= 1'b0;
    end else begin
      use2_q <= ctl_i.use_nb;
      use3_q <= use2_q;
      use4_q <= use3_q;
    end
  end

  // norm and weighted sum
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      norm_q <= '0;
      sum_q  <= '0;
    end else if (use4_q) begin
      norm_q <= norm_q + NORM_W'(wt3_q);
      sum_q  <= sum_q + SUM_W'(prod_q);
    end
  end

  // restoring divide, one quotient bit per cycle
  assign take = (rem_q >= dv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q  <= DIV_W'(sum_q) + DIV_W'(norm_q >> 1);
      dv_q   <= DIV_W'(norm_q) << 7;
      zero_q <= (norm_q == '0);
      quo_q  <= '0;
    end else if (busy_q) begin
      if (take) begin
        rem_q <= rem_q - dv_q;
      end
      dv_q  <= dv_q >> 1;
      quo_q <= {quo_q[6:0], take};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.res  = zero_q ? centre_i : quo_q;

endmodule
`default_nettype wire

FILE: hdl/bilateral_filter_rgb_top.sv
// ----------------------------------------------------------------------------
// bilateral_filter_rgb_top: streaming RGB bilateral filter
// Ring line store, window sequencer, three channel lanes and output merge.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  in      | in_valid_i/in_ready_o, cmd, pix, tbl | into block
//  out     | out_valid_o/out_ready_i, rgb, end    | out of block
//  cfg     | cfg_valid_i/cfg_ready_o, index, data | into block
//
//  pixel without result, flush without result, table write: taken while idle
//  an item with a result walks its whole window: one window neighbour
//  per cycle through the single read port of the line store, then 8 divide steps
//  a result that is not taken holds the block before its next result only
//  reset clears the counters and pending count; store and tables are unset
`default_nettype none
module bilateral_filter_rgb_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  pix_blue_i,
  input  wire logic [7:0]  pix_green_i,
  input  wire logic [7:0]  pix_red_i,
  input  wire logic [7:0]  table_index_i,
  input  wire logic [15:0] table_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_blue_o,
  output logic [7:0]       out_green_o,
  output logic [7:0]       out_red_o,
  output logic             frame_end_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [12:0] cfg_data_i
);
  import bfr_pkg::*;

  localparam logic [RING_AW:0] RING = (RING_AW + 1)'(RING_SIZE);

  bfr_state_e state_q, state_d;

  logic [2:0]         half_q;
  logic [10:0]        width_q;
  logic [12:0]        height_q;
  logic [HW_BITS-1:0] eff_h;
  logic [COL_W:0]     eff_w;
  logic [ROW_W:0]     eff_ht;
  logic [PEND_W-1:0]  delay;

  logic [RING_AW-1:0] wp_q, cur_q, row_q, centre_pos, start_pos;
  logic [PEND_W-1:0]  pend_q, pend_inc;
  logic [COL_W-1:0]   ocol_q;
  logic [ROW_W-1:0]   orow_q;
  logic signed [OFS_W-1:0] ii_q, jj_q;
  logic [23:0]        centre_q;
  logic [4:0]         lst_q;
  logic               use1_q;

  logic acc_in, acc_cfg, emit_px, emit_fl, loop_last, in_img;
  logic load_out;
  logic [RING_AW:0]   diff_c, diff_s, row_nx, cur_nx;
  logic [HW_BITS-1:0] abs_i, abs_j;
  logic [2*HW_BITS:0] sq_sum;
  logic signed [ROW_W+1:0] ny;
  logic signed [COL_W+1:0] nx;

  logic [23:0]            ring_rdata;
  logic [WEIGHT_BITS-1:0] sw;
  bfr_tbl_wr_t            tbl_wr;
  bfr_lane_ctl_t          lane_ctl;
  bfr_lane_sts_t          sts [LANES];

  // effective register values
  always_comb begin
    eff_h  = (32'(half_q) > HALF_MAX) ? HW_BITS'(HALF_MAX) : HW_BITS'(half_q);
    eff_w  = (width_q == '0) ? (COL_W + 1)'(1) :
             ((32'(width_q) > LINE_MAX) ? (COL_W + 1)'(LINE_MAX) : (COL_W + 1)'(width_q));
    eff_ht = (height_q == '0) ? (ROW_W + 1)'(1) :
             ((32'(height_q) > HEIGHT_LIMIT) ? (ROW_W + 1)'(HEIGHT_LIMIT) :
              (ROW_W + 1)'(height_q));
    delay  = PEND_W'(eff_h * eff_w) + PEND_W'(eff_h);
  end

  assign acc_in   = in_valid_i && in_ready_o;
  assign acc_cfg  = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o = 1'b1;
  assign pend_inc = pend_q + PEND_W'(1);
  assign emit_px  = (bfr_cmd_e'(cmd_i) == CMD_PIXEL) && (pend_inc > delay);
  assign emit_fl  = (bfr_cmd_e'(cmd_i) == CMD_FLUSH) && (pend_q != '0);
  assign loop_last = (ii_q == OFS_W'(eff_h)) && (jj_q == OFS_W'(eff_h));
  assign load_out = (state_q == ST_DONE) && (!out_valid_o || out_ready_i);

  // ring positions of the centre, of the window's first neighbour and of the walk's next steps
  always_comb begin
    diff_c = {1'b0, wp_q} - (RING_AW + 1)'(pend_q);
    if (wp_q < RING_AW'(pend_q)) begin
      diff_c = diff_c + RING;
    end
    centre_pos = diff_c[RING_AW-1:0];
    diff_s = {1'b0, centre_pos} - (RING_AW + 1)'(delay);
    if (centre_pos < RING_AW'(delay)) begin
      diff_s = diff_s + RING;
    end
    start_pos = diff_s[RING_AW-1:0];
    row_nx = {1'b0, row_q} + (RING_AW + 1)'(eff_w);
    if (row_nx >= RING) begin
      row_nx = row_nx - RING;
    end
    cur_nx = {1'b0, cur_q} + (RING_AW + 1)'(1);
    if (cur_nx >= RING) begin
      cur_nx = '0;
    end
  end

  // neighbour offset checks and space table index
  always_comb begin
    abs_i  = ii_q[OFS_W-1] ? HW_BITS'(-ii_q) : HW_BITS'(ii_q);
    abs_j  = jj_q[OFS_W-1] ? HW_BITS'(-jj_q) : HW_BITS'(jj_q);
    sq_sum = (2 * HW_BITS + 1)'(abs_i * abs_i) + (2 * HW_BITS + 1)'(abs_j * abs_j);
    ny     = $signed({2'b00, orow_q}) + (ROW_W + 2)'(jj_q);
    nx     = $signed({2'b00, ocol_q}) + (COL_W + 2)'(ii_q);
    in_img = (ny >= 0) && (ny < $signed({1'b0, eff_ht})) &&
             (nx >= 0) && (nx < $signed({1'b0, eff_w}));
  end

  // sequencer next state and handshake
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (emit_px || emit_fl)) begin
          state_d = ST_CRD;
        end
      end
      ST_CRD:   state_d = ST_SETUP;
      ST_SETUP: state_d = ST_LOOP;
      ST_LOOP: begin
        if (loop_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (lst_q[4]) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!sts[0].busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q   <= 3'd7;
      width_q  <= 11'd1024;
      height_q <= 13'd1024;
    end else if (acc_cfg) begin
      unique case (cfg_index_i)
        CFG_HALF:   half_q   <= cfg_data_i[2:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[10:0];
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // write pointer, pending count and output position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      pend_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else if (acc_cfg && (cfg_index_i == CFG_HALF || cfg_index_i == CFG_WIDTH ||
                             cfg_index_i == CFG_HEIGHT)) begin
      pend_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else if (acc_in && bfr_cmd_e'(cmd_i) == CMD_PIXEL) begin
      wp_q   <= (wp_q == RING_AW'(RING_SIZE - 1)) ? '0 : wp_q + RING_AW'(1);
      pend_q <= pend_inc;
    end else if (load_out) begin
      pend_q <= pend_q - PEND_W'(1);
      if ((COL_W + 1)'(ocol_q) + (COL_W + 1)'(1) >= eff_w) begin
        ocol_q <= '0;
        if ((ROW_W + 1)'(orow_q) + (ROW_W + 1)'(1) >= eff_ht) begin
          orow_q <= '0;
        end else begin
          orow_q <= orow_q + ROW_W'(1);
        end
      end else begin
        ocol_q <= ocol_q + COL_W'(1);
      end
    end
  end

  // window walk over the ring
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CRD) begin
      row_q <= start_pos;
      cur_q <= start_pos;
      ii_q  <= -OFS_W'(eff_h);
      jj_q  <= -OFS_W'(eff_h);
    end else if (state_q == ST_LOOP) begin
      if (ii_q == OFS_W'(eff_h)) begin
        ii_q  <= -OFS_W'(eff_h);
        jj_q  <= jj_q + OFS_W'(1);
        row_q <= row_nx[RING_AW-1:0];
        cur_q <= row_nx[RING_AW-1:0];
      end else begin
        ii_q  <= ii_q + OFS_W'(1);
        cur_q <= cur_nx[RING_AW-1:0];
      end
    end
    if (state_q == ST_SETUP) begin
      centre_q <= ring_rdata;
    end
  end

  // neighbour valid and end-of-window markers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use1_q <= 1'b0;
      lst_q  <= '0;
    end else begin
      use1_q <= (state_q == ST_LOOP) && in_img;
      lst_q  <= {lst_q[3:0], (state_q == ST_LOOP) && loop_last};
    end
  end

  bfr_ram #(.WIDTH(24), .DEPTH(RING_SIZE)) u_ring (
    .clk_i   (clk_i),
    .we_i    (acc_in && bfr_cmd_e'(cmd_i) == CMD_PIXEL),
    .waddr_i (wp_q),
    .wdata_i ({pix_red_i, pix_green_i, pix_blue_i}),
    .re_i    (state_q == ST_CRD || state_q == ST_LOOP),
    .raddr_i ((state_q == ST_CRD) ? centre_pos : cur_q),
    .rdata_o (ring_rdata)
  );

  bfr_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(SPACE_DEPTH)) u_space (
    .clk_i   (clk_i),
    .we_i    (acc_in && bfr_cmd_e'(cmd_i) == CMD_SPACE &&
              (32'(table_index_i) < SPACE_DEPTH)),
    .waddr_i (SPACE_AW'(table_index_i)),
    .wdata_i (WEIGHT_BITS'(table_value_i)),
    .re_i    (state_q == ST_LOOP),
    .raddr_i (sq_sum[SPACE_AW-1:0]),
    .rdata_o (sw)
  );

  // lane control and colour table broadcast
  assign tbl_wr.we       = acc_in && bfr_cmd_e'(cmd_i) == CMD_COLOUR;
  assign tbl_wr.addr     = table_index_i;
  assign tbl_wr.data     = WEIGHT_BITS'(table_value_i);
  assign lane_ctl.clr    = (state_q == ST_SETUP);
  assign lane_ctl.use_nb = use1_q;
  assign lane_ctl.start  = (state_q == ST_DRAIN) && lst_q[4];

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    bfr_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tbl_wr_i (tbl_wr),
      .ctl_i    (lane_ctl),
      .sample_i (ring_rdata[8*k +: 8]),
      .centre_i (centre_q[8*k +: 8]),
      .sw_i     (sw),
      .sts_o    (sts[k])
    );
  end

  // merged output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_blue_o  <= sts[0].res;
      out_green_o <= sts[1].res;
      out_red_o   <= sts[2].res;
      frame_end_o <= ((ROW_W + 1)'(orow_q) == eff_ht - (ROW_W + 1)'(1)) &&
                     ((COL_W + 1)'(ocol_q) == eff_w - (COL_W + 1)'(1));
    end
  end

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (pend_q <= delay))
    else $error("pending count above output delay while idle");

  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts[0].busy |-> (state_q == ST_DIV))
    else $error("divider running outside divide state");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("output item without finished window");
`endif

endmodule
`default_nettype wire
